// File: sv/gbr_pkg.sv
// shared types, widths and constants of the gas baseline ratio classifier
`timescale 1ns / 1ps
`default_nettype none

package gbr_pkg;

   // field widths
   localparam int ADC_BITS  = 12;
   localparam int BASE_W    = 20;
   localparam int INDEX_W   = 20;
   localparam int LIMIT_W   = 16;
   localparam int WARM_W    = 8;
   localparam int CLASS_W   = 2;

   // default group length
   localparam int DEF_SAMPLES = 8;

   // queue between front and back
   localparam int FIFO_DEPTH = 2;

   // index divider: reading shifted up by 16 over the baseline
   localparam int DVD_W = ADC_BITS + 16;

   // baseline limits, q12.8
   localparam logic [BASE_W-1:0] BASE_ONE = 20'd256;
   localparam logic [BASE_W-1:0] BASE_MAX = 20'hFFFFF;

   // exponential average: (9*b + r*256 + 5) / 10 via reciprocal
   localparam int EMA_W     = 24;
   localparam int EMA_SHIFT = 28;
   localparam int RECIP10_W = 25;
   localparam logic [RECIP10_W-1:0] EMA_RECIP10 = 25'd26843546;
   localparam logic [3:0] EMA_MULT  = 4'd9;
   localparam logic [3:0] EMA_ROUND = 4'd5;

   // class codes
   localparam logic [CLASS_W-1:0] CLASS_HAPPY   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_NEUTRAL = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_MAD     = 2'd2;

   // register port
   localparam int PADDR_W   = 4;
   localparam int PDATA_W   = 32;
   localparam int REG_IDX_W = 2;
   localparam logic [REG_IDX_W-1:0] REG_HAPPY_LIMIT     = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_NEUTRAL_LIMIT   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_WARMUP_READINGS = 2'd2;

   localparam logic [LIMIT_W-1:0] RST_HAPPY_LIMIT     = 16'd307;
   localparam logic [LIMIT_W-1:0] RST_NEUTRAL_LIMIT   = 16'd422;
   localparam logic [WARM_W-1:0]  RST_WARMUP_READINGS = 8'd20;

   // configuration seen by the back end
   typedef struct packed {
      logic [LIMIT_W-1:0] happy_limit;
      logic [LIMIT_W-1:0] neutral_limit;
      logic [WARM_W-1:0]  warmup_readings;
   } gbr_cfg_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } gbr_fifo_stat_type;

   // divider request and response
   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dividend;
      logic [BASE_W-1:0] divisor;
   } gbr_div_req_type;

   typedef struct packed {
      logic               done;
      logic [INDEX_W-1:0] quotient;
   } gbr_div_rsp_type;

endpackage

`default_nettype wire

// File: sv/gbr_front.sv
// front end: accepts samples and sums each group into the queue
`timescale 1ns / 1ps
`default_nettype none

module gbr_front #(
   parameter int SAMPLES_PER_READING = gbr_pkg::DEF_SAMPLES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gbr_pkg::ADC_BITS-1:0]      req_adc_sample,
   input  wire gbr_pkg::gbr_fifo_stat_type        fifo_stat,
   output logic                                   push,
   output logic [gbr_pkg::ADC_BITS+$clog2(SAMPLES_PER_READING)-1:0] push_sum
);
   import gbr_pkg::*;

   localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_READING);
   localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_READING - 1);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   logic             accept;

   // last beat of a group needs room in the queue
   assign last      = (count_ff == LAST_CNT);
   assign req_ready = !(last && fifo_stat.full);
   assign accept    = req_valid && req_ready;
   assign sum_next  = sum_ff + SUM_W'(req_adc_sample);
   assign push      = accept && last;
   assign push_sum  = sum_next;

   // group accumulator
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/gbr_fifo.sv
// short queue of group sums between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module gbr_fifo #(
   parameter int WIDTH = 15,
   parameter int DEPTH = gbr_pkg::FIFO_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   input  wire logic                       pop,
   output logic [WIDTH-1:0]                pop_data,
   output gbr_pkg::gbr_fifo_stat_type      fifo_stat
);
   import gbr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign fifo_stat.full  = (count_ff == FULL_CNT);
   assign fifo_stat.empty = (count_ff == '0);
   assign pop_data        = data_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   // no overflow or underflow
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!fifo_stat.full || pop))
      else $error("group sum pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_stat.empty)
      else $error("group sum popped from empty queue");

endmodule

`default_nettype wire

// File: sv/gbr_div.sv
// restoring divider for the air index, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module gbr_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gbr_pkg::gbr_div_req_type   div_req,
   output gbr_pkg::gbr_div_rsp_type        div_rsp
);
   import gbr_pkg::*;

   // quotient fits INDEX_W bits since the divisor is at least 1.0
   localparam int CNT_W = $clog2(INDEX_W + 1);

   logic [BASE_W-1:0]  rem_ff, rem_in;
   logic [INDEX_W-1:0] quo_ff, quo_in;
   logic [BASE_W-1:0]  divisor_ff, divisor_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BASE_W:0]    trial;
   logic [BASE_W:0]    diff;
   logic               ge;

   assign trial = {rem_ff, quo_ff[INDEX_W-1]};
   assign ge    = (trial >= {1'b0, divisor_ff});
   assign diff  = trial - {1'b0, divisor_ff};

   // shift and subtract step
   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         rem_in     = BASE_W'(div_req.dividend[DVD_W-1:INDEX_W]);
         quo_in     = div_req.dividend[INDEX_W-1:0];
         divisor_in = div_req.divisor;
         cnt_in     = CNT_W'(INDEX_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
         quo_in = {quo_ff[INDEX_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // a new division never cuts into a running one
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

endmodule

`default_nettype wire

// File: sv/gbr_back.sv
// back end: reading, baseline update, index division, class and result register
`timescale 1ns / 1ps
`default_nettype none

module gbr_back #(
   parameter int SAMPLES_PER_READING = gbr_pkg::DEF_SAMPLES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire gbr_pkg::gbr_cfg_type              cfg,
   input  wire gbr_pkg::gbr_fifo_stat_type        fifo_stat,
   input  wire logic [gbr_pkg::ADC_BITS+$clog2(SAMPLES_PER_READING)-1:0] pop_data,
   output logic                                   pop,
   output gbr_pkg::gbr_div_req_type               div_req,
   input  wire gbr_pkg::gbr_div_rsp_type          div_rsp,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gbr_pkg::ADC_BITS-1:0]           rsp_reading_average,
   output logic [gbr_pkg::BASE_W-1:0]             rsp_baseline_level,
   output logic [gbr_pkg::INDEX_W-1:0]            rsp_air_index,
   output logic [gbr_pkg::CLASS_W-1:0]            rsp_air_class,
   output logic                                   rsp_warming_up
);
   import gbr_pkg::*;

   // group mean by exact reciprocal multiply
   localparam int SUM_W       = ADC_BITS + $clog2(SAMPLES_PER_READING);
   localparam int SCALE_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
   localparam int RS_W        = SCALE_SHIFT + 1;
   localparam int PS_W        = SUM_W + RS_W;
   localparam logic [RS_W-1:0] RECIP_S = RS_W'(((64'd1 << SCALE_SHIFT)
      + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));
   localparam int EP_W = EMA_W + RECIP10_W;

   // sequencer codes
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCALE = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_EMA   = 4'd3;
   localparam logic [3:0] ST_PROD  = 4'd4;
   localparam logic [3:0] ST_BASE  = 4'd5;
   localparam logic [3:0] ST_DIV   = 4'd6;
   localparam logic [3:0] ST_WAIT  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [PS_W-1:0]     sprod_ff, sprod_in;
   logic [ADC_BITS-1:0] reading_ff, reading_in;
   logic                warming_ff, warming_in;
   logic [EMA_W-1:0]    acc_ff, acc_in;
   logic [EP_W-1:0]     eprod_ff, eprod_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic                first_ff, first_in;
   logic [WARM_W-1:0]   done_cnt_ff, done_cnt_in;

   logic                out_valid_ff, out_valid_in;
   logic [ADC_BITS-1:0] out_avg_ff, out_avg_in;
   logic [BASE_W-1:0]   out_base_ff, out_base_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [CLASS_W-1:0]  out_class_ff, out_class_in;
   logic                out_warm_ff, out_warm_in;

   logic                out_free;
   logic [CLASS_W-1:0]  air_class;
   logic [BASE_W-1:0]   reading_up;

   // clamp into 1.0 .. max baseline
   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W:0] v);
      logic [BASE_W-1:0] r;
      if (v < {1'b0, BASE_ONE}) begin
         r = BASE_ONE;
      end else if (v > {1'b0, BASE_MAX}) begin
         r = BASE_MAX;
      end else begin
         r = v[BASE_W-1:0];
      end
      return r;
   endfunction

   assign out_free   = !out_valid_ff || rsp_ready;
   assign pop        = (state_ff == ST_IDLE) && !fifo_stat.empty;
   assign reading_up = {reading_ff, 8'd0};

   // index request to the divider
   assign div_req.start    = (state_ff == ST_DIV);
   assign div_req.dividend = {reading_ff, 16'd0};
   assign div_req.divisor  = base_ff;

   // class against the two limits, neutral while warming
   always_comb begin
      if (warming_ff) begin
         air_class = CLASS_NEUTRAL;
      end else if (div_rsp.quotient <= INDEX_W'(cfg.happy_limit)) begin
         air_class = CLASS_HAPPY;
      end else if (div_rsp.quotient <= INDEX_W'(cfg.neutral_limit)) begin
         air_class = CLASS_NEUTRAL;
      end else begin
         air_class = CLASS_MAD;
      end
   end

   // per-reading sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      sprod_in     = sprod_ff;
      reading_in   = reading_ff;
      warming_in   = warming_ff;
      acc_in       = acc_ff;
      eprod_in     = eprod_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      done_cnt_in  = done_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_avg_in   = out_avg_ff;
      out_base_in  = out_base_ff;
      out_index_in = out_index_ff;
      out_class_in = out_class_ff;
      out_warm_in  = out_warm_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               sum_in   = pop_data;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            sprod_in = PS_W'(sum_ff) * PS_W'(RECIP_S);
            state_in = ST_READ;
         end
         ST_READ: begin
            reading_in = sprod_ff[SCALE_SHIFT +: ADC_BITS];
            warming_in = (done_cnt_ff < cfg.warmup_readings);
            state_in   = ST_EMA;
         end
         ST_EMA: begin
            acc_in = EMA_W'(base_ff) * EMA_W'(EMA_MULT) + EMA_W'(reading_up)
               + EMA_W'(EMA_ROUND);
            state_in = ST_PROD;
         end
         ST_PROD: begin
            eprod_in = EP_W'(acc_ff) * EP_W'(EMA_RECIP10);
            state_in = ST_BASE;
         end
         ST_BASE: begin
            if (!first_ff) begin
               base_in  = clamp_base({1'b0, reading_up});
               first_in = 1'b1;
            end else if (warming_ff) begin
               base_in = clamp_base(eprod_ff[EMA_SHIFT +: BASE_W+1]);
            end
            if (done_cnt_ff != '1) begin
               done_cnt_in = done_cnt_ff + WARM_W'(1);
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_avg_in   = reading_ff;
               out_base_in  = base_ff;
               out_index_in = div_rsp.quotient;
               out_class_in = air_class;
               out_warm_in  = warming_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= BASE_ONE;
         first_ff     <= 1'b0;
         done_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         first_ff     <= first_in;
         done_cnt_ff  <= done_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      sprod_ff     <= sprod_in;
      reading_ff   <= reading_in;
      warming_ff   <= warming_in;
      acc_ff       <= acc_in;
      eprod_ff     <= eprod_in;
      out_avg_ff   <= out_avg_in;
      out_base_ff  <= out_base_in;
      out_index_ff <= out_index_in;
      out_class_ff <= out_class_in;
      out_warm_ff  <= out_warm_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_reading_average = out_avg_ff;
   assign rsp_baseline_level  = out_base_ff;
   assign rsp_air_index       = out_index_ff;
   assign rsp_air_class       = out_class_ff;
   assign rsp_warming_up      = out_warm_ff;

   // baseline never drops below 1.0
   a_base_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_baseline_level >= BASE_ONE))
      else $error("baseline below 1.0 on result beat");

   // warm-up beats carry the neutral class
   a_warm_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_warming_up) |-> (rsp_air_class == CLASS_NEUTRAL))
      else $error("warm-up reading not neutral");

   // divider answers only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WAIT))
      else $error("divider result outside wait state");

endmodule

`default_nettype wire

// File: sv/gas_baseline_ratio_classifier.sv
// top level: register port, front end, queue, divider and back end
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_adc_sample
//  rsp      out        rsp_valid/rsp_ready   reading_average, baseline_level,
//                                            air_index, air_class, warming_up
//  csr      in/out     psel/penable/pready   paddr, pwdata, pwrite, prdata
//
// the front takes one sample a cycle, but holds a group's last sample while
// the queue is full; every SAMPLES_PER_READING-th sample pushes a group sum
// into a two-entry queue; the back handles one reading at a time, waits on
// the 20-step index divider for each and pops the next group sum only once
// the result register has taken the last result
// reset is synchronous; no clearing pass
// a stalled result holds in the output register while the front keeps
// accepting until the queue is full
`timescale 1ns / 1ps
`default_nettype none

module gas_baseline_ratio_classifier #(
   parameter int SAMPLES_PER_READING = gbr_pkg::DEF_SAMPLES
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gbr_pkg::ADC_BITS-1:0]      req_adc_sample,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gbr_pkg::ADC_BITS-1:0]           rsp_reading_average,
   output logic [gbr_pkg::BASE_W-1:0]             rsp_baseline_level,
   output logic [gbr_pkg::INDEX_W-1:0]            rsp_air_index,
   output logic [gbr_pkg::CLASS_W-1:0]            rsp_air_class,
   output logic                                   rsp_warming_up,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [gbr_pkg::PADDR_W-1:0]       paddr,
   input  wire logic [gbr_pkg::PDATA_W-1:0]       pwdata,
   output logic [gbr_pkg::PDATA_W-1:0]            prdata,
   output logic                                   pready
);
   import gbr_pkg::*;

   localparam int SUM_W = ADC_BITS + $clog2(SAMPLES_PER_READING);

   logic [LIMIT_W-1:0]   happy_ff, happy_in;
   logic [LIMIT_W-1:0]   neutral_ff, neutral_in;
   logic [WARM_W-1:0]    warmup_ff, warmup_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;
   gbr_cfg_type          cfg;
   gbr_fifo_stat_type    fifo_stat;
   logic                 push;
   logic                 pop;
   logic [SUM_W-1:0]     push_sum;
   logic [SUM_W-1:0]     pop_data;
   gbr_div_req_type      div_req;
   gbr_div_rsp_type      div_rsp;

   // register port
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[REG_IDX_W+1:2];

   always_comb begin
      happy_in   = happy_ff;
      neutral_in = neutral_ff;
      warmup_in  = warmup_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_HAPPY_LIMIT:     happy_in   = pwdata[LIMIT_W-1:0];
            REG_NEUTRAL_LIMIT:   neutral_in = pwdata[LIMIT_W-1:0];
            REG_WARMUP_READINGS: warmup_in  = pwdata[WARM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         happy_ff   <= RST_HAPPY_LIMIT;
         neutral_ff <= RST_NEUTRAL_LIMIT;
         warmup_ff  <= RST_WARMUP_READINGS;
      end else begin
         happy_ff   <= happy_in;
         neutral_ff <= neutral_in;
         warmup_ff  <= warmup_in;
      end
   end

   // register read
   always_comb begin
      case (reg_idx)
         REG_HAPPY_LIMIT:     prdata = PDATA_W'(happy_ff);
         REG_NEUTRAL_LIMIT:   prdata = PDATA_W'(neutral_ff);
         REG_WARMUP_READINGS: prdata = PDATA_W'(warmup_ff);
         default:             prdata = '0;
      endcase
   end

   assign cfg.happy_limit     = happy_ff;
   assign cfg.neutral_limit   = neutral_ff;
   assign cfg.warmup_readings = warmup_ff;

   // sample accumulation
   gbr_front #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_adc_sample (req_adc_sample),
      .fifo_stat      (fifo_stat),
      .push           (push),
      .push_sum       (push_sum)
   );

   // group sum queue
   gbr_fifo #(
      .WIDTH (SUM_W),
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_sum),
      .pop       (pop),
      .pop_data  (pop_data),
      .fifo_stat (fifo_stat)
   );

   // index divider
   gbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // reading processing and result register
   gbr_back #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .fifo_stat           (fifo_stat),
      .pop_data            (pop_data),
      .pop                 (pop),
      .div_req             (div_req),
      .div_rsp             (div_rsp),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_reading_average (rsp_reading_average),
      .rsp_baseline_level  (rsp_baseline_level),
      .rsp_air_index       (rsp_air_index),
      .rsp_air_class       (rsp_air_class),
      .rsp_warming_up      (rsp_warming_up)
   );

endmodule

`default_nettype wire

// File: tb/tb.sv
// testbench of the gas baseline ratio classifier: sample groups, register phases, scoreboard
`timescale 1ns / 1ps

module tb;
   import gbr_pkg::*;

   localparam int GROUP_LEN     = DEF_SAMPLES;
   localparam int ADC_TOP       = (1 << ADC_BITS) - 1;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [63:0] INDEX_TOP = (64'd1 << INDEX_W) - 1;
   // address past the last register, writes there must change nothing
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [ADC_BITS-1:0] reading_average;
      logic [BASE_W-1:0]   baseline_level;
      logic [INDEX_W-1:0]  air_index;
      logic [CLASS_W-1:0]  air_class;
      logic                warming_up;
   } reading_result_type;

   // tracks baseline, warm-up and limits; queues the reading each full group gives
   class reading_tracker_type;
      logic [LIMIT_W-1:0]  happy_limit;
      logic [LIMIT_W-1:0]  neutral_limit;
      logic [WARM_W-1:0]   warmup_len;
      logic [14:0]         sample_sum;
      int unsigned         samples_in_group;
      logic [BASE_W-1:0]   baseline;
      logic [7:0]          readings_done;
      bit                  first_seen;
      reading_result_type  pending_readings[$];
      int unsigned         errors;

      function new();
         happy_limit      = RST_HAPPY_LIMIT;
         neutral_limit    = RST_NEUTRAL_LIMIT;
         warmup_len       = RST_WARMUP_READINGS;
         sample_sum       = '0;
         samples_in_group = 0;
         baseline         = BASE_ONE;
         readings_done    = '0;
         first_seen       = 1'b0;
         errors           = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void set_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] data);
         case (idx)
            REG_HAPPY_LIMIT:     happy_limit = data[LIMIT_W-1:0];
            REG_NEUTRAL_LIMIT:   neutral_limit = data[LIMIT_W-1:0];
            REG_WARMUP_READINGS: warmup_len = data[WARM_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [BASE_W-1:0] clamp_baseline(logic [63:0] v);
         if (v < 64'(BASE_ONE)) return BASE_ONE;
         if (v > 64'(BASE_MAX)) return BASE_MAX;
         return v[BASE_W-1:0];
      endfunction

      function void take_sample(logic [ADC_BITS-1:0] s);
         logic [63:0]         acc;
         logic [63:0]         quo;
         logic [ADC_BITS-1:0] reading;
         bit                  warming;
         reading_result_type  r;
         sample_sum += s;
         samples_in_group++;
         if (samples_in_group < GROUP_LEN) return;
         reading = ADC_BITS'(sample_sum / GROUP_LEN);
         sample_sum = '0;
         samples_in_group = 0;
         warming = readings_done < warmup_len;

         // baseline: loaded by the first reading, averaged during warm-up, then held
         if (!first_seen) begin
            baseline = clamp_baseline(64'(reading) << 8);
            first_seen = 1'b1;
         end else if (warming) begin
            acc = 64'd9 * 64'(baseline) + (64'(reading) << 8) + 64'd5;
            baseline = clamp_baseline(acc / 64'd10);
         end

         // ratio in q.8, saturated
         quo = (64'(reading) << 16) / 64'(baseline);
         if (quo > INDEX_TOP) quo = INDEX_TOP;

         r.reading_average = reading;
         r.baseline_level  = baseline;
         r.air_index       = quo[INDEX_W-1:0];
         r.warming_up      = warming;
         if (warming) r.air_class = CLASS_NEUTRAL;
         else if (quo <= 64'(happy_limit)) r.air_class = CLASS_HAPPY;
         else if (quo <= 64'(neutral_limit)) r.air_class = CLASS_NEUTRAL;
         else r.air_class = CLASS_MAD;

         if (readings_done != 8'hFF) readings_done++;
         pending_readings.push_back(r);
      endfunction

      function void check_reading(reading_result_type got);
         reading_result_type exp;
         if (pending_readings.size() == 0) begin
            flag($sformatf("unexpected reading: avg=%0d base=%0d idx=%0d class=%0d warm=%0d",
                           got.reading_average, got.baseline_level, got.air_index,
                           got.air_class, got.warming_up));
            return;
         end
         exp = pending_readings.pop_front();
         if (got.reading_average !== exp.reading_average ||
             got.baseline_level !== exp.baseline_level ||
             got.air_index !== exp.air_index ||
             got.air_class !== exp.air_class ||
             got.warming_up !== exp.warming_up)
            flag($sformatf({"reading mismatch: expected avg=%0d base=%0d idx=%0d class=%0d ",
                            "warm=%0d, got avg=%0d base=%0d idx=%0d class=%0d warm=%0d"},
                           exp.reading_average, exp.baseline_level, exp.air_index,
                           exp.air_class, exp.warming_up, got.reading_average,
                           got.baseline_level, got.air_index, got.air_class,
                           got.warming_up));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ADC_BITS-1:0]   req_adc_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ADC_BITS-1:0]   rsp_reading_average;
   logic [BASE_W-1:0]     rsp_baseline_level;
   logic [INDEX_W-1:0]    rsp_air_index;
   logic [CLASS_W-1:0]    rsp_air_class;
   logic                  rsp_warming_up;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [PADDR_W-1:0]    paddr = '0;
   logic [PDATA_W-1:0]    pwdata = '0;
   logic [PDATA_W-1:0]    prdata;
   logic                  pready;

   reading_tracker_type   tracker;
   bit                    calm = 1'b0;
   int                    stall_left = 0;

   gas_baseline_ratio_classifier i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_adc_sample      (req_adc_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_reading_average (rsp_reading_average),
      .rsp_baseline_level  (rsp_baseline_level),
      .rsp_air_index       (rsp_air_index),
      .rsp_air_class       (rsp_air_class),
      .rsp_warming_up      (rsp_warming_up),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #4 clock = ~clock;

   // result side: check each beat, then hold ready low for a random stall
   always @(posedge clock) begin : result_sink
      int stall;
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_reading(reading_result_type'{rsp_reading_average, rsp_baseline_level,
                                                    rsp_air_index, rsp_air_class,
                                                    rsp_warming_up});
         stall = calm ? 0 : $urandom_range(0, 5);
         stall_left <= stall;
         rsp_ready <= (stall == 0);
      end else begin
         if (stall_left != 0) stall_left <= stall_left - 1;
         rsp_ready <= (stall_left <= 1);
      end
   end

   // one sample beat, after a random gap
   task automatic push_sample(input int s);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_adc_sample <= s[ADC_BITS-1:0];
      do @(posedge clock); while (!req_ready);
      tracker.take_sample(s[ADC_BITS-1:0]);
   endtask

   // stop sending, let every queued reading come out, then let the back end settle
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (tracker.pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apb_access(input bit wr, input logic [REG_IDX_W-1:0] idx,
                             input logic [PDATA_W-1:0] data,
                             output logic [PDATA_W-1:0] rd);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // write with junk above the field, then read back the masked value
   task automatic program_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value,
                                   input int field_w);
      logic [PDATA_W-1:0] data;
      logic [PDATA_W-1:0] rd;
      data = ($urandom() << field_w) | value;
      apb_access(1'b1, idx, data, rd);
      tracker.set_register(idx, data);
      apb_access(1'b0, idx, '0, rd);
      if (rd !== PDATA_W'(value))
         tracker.flag($sformatf("register %0d read back %0h, expected %0h", idx, rd, value));
   endtask

   function automatic int sample_near(int level, int jit);
      int v;
      v = level + int'($urandom_range(0, 2 * jit)) - jit;
      if (v < 0) v = 0;
      if (v > ADC_TOP) v = ADC_TOP;
      return v;
   endfunction

   // one group of samples: uniform, extreme, around a level, or around the baseline
   task automatic send_group();
      int style;
      int level;
      int jit;
      style = $urandom_range(0, 9);
      level = 0;
      jit = 0;
      if (style == 2) begin
         level = $urandom_range(0, 1) * ADC_TOP;
      end else if (style <= 5) begin
         level = $urandom_range(0, ADC_TOP);
         jit = $urandom_range(0, 64);
      end else begin
         level = (int'(tracker.baseline >> 8) * int'($urandom_range(180, 480))) >> 8;
         jit = $urandom_range(0, 8);
      end
      repeat (GROUP_LEN)
         push_sample(style <= 1 ? int'($urandom_range(0, ADC_TOP)) : sample_near(level, jit));
   endtask

   task automatic run_phase(input int unsigned happy, input int unsigned neutral,
                            input int unsigned warm, input int groups, input bit quiet);
      wait_for_results();
      program_register(REG_HAPPY_LIMIT, happy, LIMIT_W);
      program_register(REG_NEUTRAL_LIMIT, neutral, LIMIT_W);
      program_register(REG_WARMUP_READINGS, warm, WARM_W);
      calm = quiet;
      for (int g = 0; g < groups; g++) begin
         // sender holds off until the block has drained
         if (groups >= 40 && g == groups / 2) wait_for_results();
         send_group();
      end
      // leftover samples shift the group boundary into the next phase
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, GROUP_LEN - 1)) push_sample($urandom_range(0, ADC_TOP));
   endtask

   initial begin
      logic [PDATA_W-1:0] scratch;
      int unsigned        lim;
      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first reading all zero hits the baseline floor, then full scale, then bit patterns
      repeat (GROUP_LEN) push_sample(0);
      repeat (GROUP_LEN) push_sample(ADC_TOP);
      for (int i = 0; i < GROUP_LEN; i++) push_sample(i[0] ? 'h555 : 'hAAA);

      // warm-up runs out partway through
      run_phase(307, 422, 20, 22, 1'b0);

      // write past the last register
      wait_for_results();
      scratch = $urandom();
      apb_access(1'b1, REG_SPARE, scratch, scratch);
      tracker.set_register(REG_SPARE, scratch);

      // limits at their extremes, no warm-up
      run_phase(0, 65535, 0, 12, 1'b1);
      run_phase(65535, 0, 0, 10, 1'b0);
      // longest warm-up: baseline adapts again
      run_phase(200, 300, 255, 15, 1'b0);
      lim = $urandom_range(150, 350);
      run_phase(lim, lim + $urandom_range(0, 200), $urandom_range(0, 255), 40, 1'b0);
      run_phase(0, 0, 0, 10, 1'b1);
      // neutral limit below happy limit
      run_phase(400, 250, $urandom_range(0, 255), 25, 1'b0);
      // reopened warm-up runs out again partway through a long run
      lim = $urandom_range(230, 330);
      run_phase(lim, lim + $urandom_range(0, 150), 150, 43, 1'b0);

      wait_for_results();
      repeat (60) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_readings.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
